// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block, ddpl_checker.
// Clocked on i_clk; the first form is masked while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is skipped while reset is held.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: check failed");

// Check that also runs through reset.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("%m: check failed");

`endif

// File: rtl/ddpl_pkg.sv
// Shared types and constants of the differential drive position loop.
// No dependencies; used by ddpl_mul, ddpl_mod and the top module.
`default_nettype none

package ddpl_pkg;

    // controller constants
    localparam logic signed [15:0] SPEED_MAX         = 16'sd3000;
    localparam logic signed [16:0] BRAKE_COEF        = 17'sd1000;
    localparam logic        [9:0]  GAIN_P            = 10'd320;
    localparam logic signed [15:0] KICK_POS          = 16'sd70;
    localparam logic signed [15:0] KICK_NEG_STRAIGHT = -16'sd10;
    localparam logic signed [15:0] KICK_NEG_TURN     = -16'sd70;
    localparam int                 RATIO_SHIFT       = 16;

    // shared multiplier widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // tick counter and remainder unit
    localparam int COUNT_W    = 8;
    localparam int DIVIDEND_W = COUNT_W + 1;
    localparam int MOD_STEP_W = $clog2(DIVIDEND_W + 1);

    typedef enum logic [2:0] {
        CFG_MODE            = 3'd0,
        CFG_TARGET_DISTANCE = 3'd1,
        CFG_TARGET_ANGLE    = 3'd2,
        CFG_SPEED_RATIO     = 3'd3,
        CFG_ACCEL_DIVIDER   = 3'd4,
        CFG_DRIVE_LIMIT     = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATIO,
        ST_SQUARE,
        ST_SCALE,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [COUNT_W-1:0]    divisor;
    } t_mod_req;

    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

// File: rtl/ddpl_mul.sv
// Shared signed multiplier with registered product.
// Depends on ddpl_pkg for operand widths.
`default_nettype none

module ddpl_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [ddpl_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [ddpl_pkg::MUL_B_W-1:0] i_b,
    output logic signed      [ddpl_pkg::MUL_P_W-1:0] o_prod
);

    logic signed [ddpl_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= ddpl_pkg::MUL_P_W'(i_a) * ddpl_pkg::MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/ddpl_mod.sv
// Restoring remainder unit, one dividend bit per cycle.
// Depends on ddpl_pkg for widths and the request/response structs.
`default_nettype none

module ddpl_mod (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ddpl_pkg::t_mod_req i_req,
    output ddpl_pkg::t_mod_rsp      o_rsp
);

    logic                                r_busy;
    logic [ddpl_pkg::MOD_STEP_W-1:0]     r_steps;
    logic [ddpl_pkg::DIVIDEND_W-1:0]     r_num;
    logic [ddpl_pkg::COUNT_W-1:0]        r_rem;
    logic [ddpl_pkg::COUNT_W-1:0]        r_div;
    logic [ddpl_pkg::COUNT_W:0]          w_trial;
    logic                                w_fits;

    assign w_trial = {r_rem, r_num[ddpl_pkg::DIVIDEND_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
        end else if (i_req.start) begin
            r_busy  <= 1'b1;
            r_steps <= ddpl_pkg::MOD_STEP_W'(ddpl_pkg::DIVIDEND_W);
        end else if (r_busy) begin
            r_steps <= r_steps - 1'b1;
            if (r_steps == ddpl_pkg::MOD_STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[ddpl_pkg::DIVIDEND_W-2:0], 1'b0};
            if (w_fits) begin
                r_rem <= ddpl_pkg::COUNT_W'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= w_trial[ddpl_pkg::COUNT_W-1:0];
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

// File: rtl/differential_drive_position_loop.sv
// Differential drive position loop: one control tick per input transfer.
// Input stream: s_tdata carries left (bits 31:0) and right (63:32) wheel counts.
// Output stream: m_tdata carries right drive, left drive and two over-limit flags.
// Configuration: i_cfg_index/i_cfg_data written on i_cfg_valid; always ready,
// to be written only while no tick is in flight.
// Timing: s_tready is high only while the sequencer is idle. A tick's result
// reaches the output register once the 9-step restoring remainder that
// advances the tick counter has finished; it runs beside the 5-step multiply
// and update sequence on the shared multiplier, and the output state waits for it.
// A new tick is taken only after the last one has been committed.
// Stalls: the result waits in the output register; the next tick can be taken
// meanwhile, and its own result is held back until the register has drained.
// Reset (synchronous, active low): controller state cleared, registers back to
// mode 0, accel divider 5, drive limit 3000, output empty.
// Depends on ddpl_pkg, ddpl_mul and ddpl_mod.
`default_nettype none

module differential_drive_position_loop (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // left_position[31:0], right_position[63:32]
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // right_drive[15:0], left_drive[31:16],
                                        // left_over_limit[32], right_over_limit[33], pad
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    logic               r_mode;
    logic signed [31:0] r_target_distance;
    logic signed [31:0] r_target_angle;
    logic signed [15:0] r_speed_ratio;
    logic        [7:0]  r_accel_divider;
    logic        [14:0] r_drive_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= 1'b0;
            r_target_distance <= '0;
            r_target_angle    <= '0;
            r_speed_ratio     <= '0;
            r_accel_divider   <= 8'd5;
            r_drive_limit     <= 15'd3000;
        end else if (i_cfg_valid) begin
            case (ddpl_pkg::t_cfg_idx'(i_cfg_index))
                ddpl_pkg::CFG_MODE:            r_mode            <= i_cfg_data[0];
                ddpl_pkg::CFG_TARGET_DISTANCE: r_target_distance <= i_cfg_data;
                ddpl_pkg::CFG_TARGET_ANGLE:    r_target_angle    <= i_cfg_data;
                ddpl_pkg::CFG_SPEED_RATIO:     r_speed_ratio     <= i_cfg_data[15:0];
                ddpl_pkg::CFG_ACCEL_DIVIDER:   r_accel_divider   <= i_cfg_data[7:0];
                ddpl_pkg::CFG_DRIVE_LIMIT:     r_drive_limit     <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- controller state ----------------
    logic        [31:0] r_distance_error;
    logic        [31:0] r_angle_error;
    logic        [63:0] r_angle_integral;
    logic        [63:0] r_distance_integral;
    logic signed [15:0] r_distance_speed;
    logic signed [15:0] r_angle_speed;
    logic        [7:0]  r_straight_count;
    logic        [7:0]  r_turn_count;

    // ---------------- per-tick working registers ----------------
    ddpl_pkg::t_state   r_state, n_state;
    logic        [31:0] r_dist;
    logic        [31:0] r_ang;
    logic        [15:0] r_delta;      // error change, kept to 16 bits
    logic        [31:0] r_err_new;    // ramp axis error after this tick
    logic        [31:0] r_pi_err;     // cross-axis error
    logic        [63:0] r_pi_int;     // cross-axis integral after this tick
    logic signed [15:0] r_speed_new;
    logic        [15:0] r_pi_cmd;
    logic               r_out_valid;
    logic        [39:0] r_out_data;

    // ---------------- shared units ----------------
    logic signed [ddpl_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [ddpl_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [ddpl_pkg::MUL_P_W-1:0] w_prod;
    ddpl_pkg::t_mod_req                  w_mod_req;
    ddpl_pkg::t_mod_rsp                  w_mod_rsp;

    ddpl_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    ddpl_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // ---------------- axis selection by mode ----------------
    // straight: distance ramped, angle under PI; turn: the other way round
    logic        [31:0] w_ramp_target, w_ramp_meas, w_ramp_err;
    logic signed [15:0] w_ramp_speed, w_kick_neg;
    logic        [7:0]  w_ramp_count;
    logic        [31:0] w_pi_drive, w_pi_other;
    logic        [63:0] w_pi_int_old;

    assign w_ramp_target = r_mode ? r_target_angle   : r_target_distance;
    assign w_ramp_meas   = r_mode ? r_ang            : r_dist;
    assign w_ramp_err    = r_mode ? r_angle_error    : r_distance_error;
    assign w_ramp_speed  = r_mode ? r_angle_speed    : r_distance_speed;
    assign w_ramp_count  = r_mode ? r_turn_count     : r_straight_count;
    assign w_kick_neg    = r_mode ? ddpl_pkg::KICK_NEG_TURN : ddpl_pkg::KICK_NEG_STRAIGHT;
    assign w_pi_drive    = r_mode ? r_ang            : r_dist;
    assign w_pi_other    = r_mode ? r_dist           : r_ang;
    assign w_pi_int_old  = r_mode ? r_distance_integral : r_angle_integral;

    // ---------------- sequencer: next state ----------------
    logic w_take, w_commit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ddpl_pkg::ST_IDLE:   if (s_tvalid) n_state = ddpl_pkg::ST_RATIO;
            ddpl_pkg::ST_RATIO:  n_state = ddpl_pkg::ST_SQUARE;
            ddpl_pkg::ST_SQUARE: n_state = ddpl_pkg::ST_SCALE;
            ddpl_pkg::ST_SCALE:  n_state = ddpl_pkg::ST_UPDATE;
            ddpl_pkg::ST_UPDATE: n_state = ddpl_pkg::ST_OUT;
            ddpl_pkg::ST_OUT: begin
                if (!w_mod_rsp.busy && (!r_out_valid || m_tready)) begin
                    n_state = ddpl_pkg::ST_IDLE;
                end
            end
            default:             n_state = ddpl_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_tready = 1'b0;
        w_commit = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            ddpl_pkg::ST_IDLE: s_tready = 1'b1;
            ddpl_pkg::ST_RATIO: begin
                // drive-axis measurement times Q16 ratio
                w_mul_a = {w_pi_drive[31], w_pi_drive};
                w_mul_b = {r_speed_ratio[15], r_speed_ratio};
            end
            ddpl_pkg::ST_SQUARE: begin
                w_mul_a = {{17{r_delta[15]}}, r_delta};
                w_mul_b = {r_delta[15], r_delta};
            end
            ddpl_pkg::ST_SCALE: begin
                // square is at most 2^30, so 31 bits hold it
                w_mul_a = {2'b00, w_prod[30:0]};
                w_mul_b = ddpl_pkg::BRAKE_COEF;
            end
            ddpl_pkg::ST_OUT: w_commit = !w_mod_rsp.busy && (!r_out_valid || m_tready);
            default: begin
            end
        endcase
    end

    assign w_take = s_tvalid && s_tready;

    // tick counter advance: (count + 1) mod divider, divider 0 acting as 1
    assign w_mod_req.start    = w_take;
    assign w_mod_req.dividend = {1'b0, w_ramp_count} + 9'd1;
    assign w_mod_req.divisor  = (r_accel_divider == 8'd0) ? 8'd1 : r_accel_divider;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddpl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- datapath ----------------
    logic [15:0] w_delta;
    assign w_delta = 16'(w_ramp_target - w_ramp_meas - w_ramp_err);

    // braking band and speed ramp
    logic [32:0]        w_e33, w_abs_e;
    logic               w_in_band, w_e_neg, w_e_zero;
    logic signed [15:0] w_tgt_speed, w_diff, w_step, w_speed1, w_speed2;

    assign w_e33     = {r_err_new[31], r_err_new};
    assign w_abs_e   = w_e33[32] ? (33'd0 - w_e33) : w_e33;
    assign w_in_band = {{(ddpl_pkg::MUL_P_W-33){1'b0}}, w_abs_e} <= $unsigned(w_prod);
    assign w_e_neg   = r_err_new[31];
    assign w_e_zero  = (r_err_new == 32'd0);

    always_comb begin
        if (w_in_band) begin
            w_tgt_speed = 16'sd0;
        end else if (w_e_neg) begin
            w_tgt_speed = -ddpl_pkg::SPEED_MAX;
        end else begin
            w_tgt_speed = ddpl_pkg::SPEED_MAX;
        end
        w_diff = w_tgt_speed - w_ramp_speed;
        if (w_ramp_count != 8'd0) begin
            w_step = 16'sd0;
        end else if (w_diff > 16'sd0) begin
            w_step = 16'sd1;
        end else if (w_diff < 16'sd0) begin
            w_step = -16'sd1;
        end else begin
            w_step = 16'sd0;
        end
        w_speed1 = w_ramp_speed + w_step;
        // minimum-speed kick
        if (!w_e_zero && (w_speed1 > w_kick_neg) && (w_speed1 < ddpl_pkg::KICK_POS)) begin
            w_speed2 = w_e_neg ? w_kick_neg : ddpl_pkg::KICK_POS;
        end else begin
            w_speed2 = w_speed1;
        end
    end

    // PI command: (320*e) >> 2 plus integral >> 8, low 16 bits only
    logic [17:0] w_p_term;
    assign w_p_term = 18'(r_pi_err[17:0] * {8'd0, ddpl_pkg::GAIN_P});

    always_ff @(posedge i_clk) begin
        case (r_state)
            ddpl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    r_dist <= s_tdata[63:32] + s_tdata[31:0];
                    r_ang  <= s_tdata[63:32] - s_tdata[31:0];
                end
            end
            ddpl_pkg::ST_RATIO: begin
                r_delta   <= w_delta;
                r_err_new <= w_ramp_err + {{16{w_delta[15]}}, w_delta};
            end
            ddpl_pkg::ST_SQUARE: begin
                r_pi_err <= w_prod[ddpl_pkg::RATIO_SHIFT+31:ddpl_pkg::RATIO_SHIFT] - w_pi_other;
            end
            ddpl_pkg::ST_SCALE: begin
                r_pi_int <= w_pi_int_old + {{32{r_pi_err[31]}}, r_pi_err};
            end
            ddpl_pkg::ST_UPDATE: begin
                r_speed_new <= w_speed2;
                r_pi_cmd    <= w_p_term[17:2] + r_pi_int[23:8];
            end
            default: begin
            end
        endcase
    end

    // ---------------- result and state commit ----------------
    logic [15:0] w_cd, w_ca, w_right, w_left;
    logic [16:0] w_mag_r, w_mag_l;
    logic        w_over_r, w_over_l;

    assign w_cd    = r_mode ? r_pi_cmd : r_speed_new;
    assign w_ca    = r_mode ? r_speed_new : r_pi_cmd;
    assign w_right = w_cd + w_ca;
    assign w_left  = w_cd - w_ca;
    assign w_mag_r = w_right[15] ? (17'd0 - {1'b1, w_right}) : {1'b0, w_right};
    assign w_mag_l = w_left[15]  ? (17'd0 - {1'b1, w_left})  : {1'b0, w_left};
    assign w_over_r = w_mag_r > {2'b00, r_drive_limit};
    assign w_over_l = w_mag_l > {2'b00, r_drive_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid         <= 1'b0;
            r_distance_error    <= '0;
            r_angle_error       <= '0;
            r_angle_integral    <= '0;
            r_distance_integral <= '0;
            r_distance_speed    <= '0;
            r_angle_speed       <= '0;
            r_straight_count    <= '0;
            r_turn_count        <= '0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
            if (r_mode) begin
                r_angle_error       <= r_err_new;
                r_angle_speed       <= r_speed_new;
                r_turn_count        <= w_mod_rsp.rem;
                r_distance_error    <= r_pi_err;
                r_distance_integral <= r_pi_int;
            end else begin
                r_distance_error <= r_err_new;
                r_distance_speed <= r_speed_new;
                r_straight_count <= w_mod_rsp.rem;
                r_angle_error    <= r_pi_err;
                r_angle_integral <= r_pi_int;
            end
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= {6'd0, w_over_r, w_over_l, w_left, w_right};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: rtl/ddpl_checker.sv
// Port-level checks for the differential drive position loop, bound to the top.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ddpl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    `ASSERT_CLK(a_out_held, m_tvalid && !m_tready |=> m_tvalid)
    `ASSERT_CLK(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata))
    // one tick at a time: busy straight after a transfer in
    `ASSERT_CLK(a_busy_after_take, s_tvalid && s_tready |=> !s_tready)
    `ASSERT_CLK(a_pad_zero, m_tvalid |-> m_tdata[39:34] == 6'd0)
    `ASSERT_ALWAYS(a_reset_state, !i_rst_n |=> !m_tvalid && s_tready)

endmodule

bind differential_drive_position_loop ddpl_checker u_ddpl_checker (.*);

`default_nettype wire

// File: tb/differential_drive_position_loop_test.sv
`timescale 1ns / 1ps
// Self-checking bench for differential_drive_position_loop: wheel positions go in, and
// every drive result is checked against an in-bench prediction of the position loop.
// Depends on ddpl_pkg (register index names) and the block's RTL.

module differential_drive_position_loop_test;

    // controller constants, held here independently of the RTL
    localparam int TOP_SPEED        = 3000;
    localparam int BRAKE_GAIN       = 1000;
    localparam int P_GAIN           = 320;
    localparam int KICK_UP          = 70;
    localparam int KICK_DN_STRAIGHT = -10;
    localparam int KICK_DN_TURN     = -70;

    localparam int HOLD_LEN       = 400;   // long output hold-off, cycles
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
    localparam int PHASES         = 14;
    localparam int PHASE_TICKS    = 100;

    // one drive result, laid out as in m_tdata[33:0]
    typedef struct packed {
        logic        right_over;
        logic        left_over;
        logic [15:0] left_drive;
        logic [15:0] right_drive;
    } t_drive_result;

    typedef struct {
        bit          turn;
        logic [31:0] target_dist;
        logic [31:0] target_ang;
        logic [15:0] ratio;
        logic [7:0]  accel_div;
        logic [14:0] limit;
    } t_drive_setup;

    // DUT ports; every input is driven to a known value from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;

    differential_drive_position_loop DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // register mirror, reset values
    bit          cfg_turn        = 1'b0;
    logic [31:0] cfg_target_dist = '0;
    logic [31:0] cfg_target_ang  = '0;
    logic [15:0] cfg_ratio       = '0;
    logic [7:0]  cfg_accel_div   = 8'd5;
    logic [14:0] cfg_limit       = 15'd3000;

    // loop state mirror, all cleared by reset
    logic [31:0] dist_err       = '0;
    logic [31:0] angle_err      = '0;
    logic [63:0] dist_integral  = '0;
    logic [63:0] angle_integral = '0;
    int          dist_speed     = 0;
    int          angle_speed    = 0;
    logic [7:0]  straight_count = '0;
    logic [7:0]  turn_count     = '0;

    t_drive_result pending_drives[$];   // predicted drives not yet seen on the output

    // idling knobs: percentages, then hold-off requests and counter
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_cnt      = 0;

    // bookkeeping
    int ticks_sent     = 0;
    int drives_checked = 0;
    int cfg_writes     = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    // wheel positions of the stimulus trajectory
    logic [31:0] pos_left  = '0;
    logic [31:0] pos_right = '0;

    // Predict one control tick: the ramped axis (distance when straight, angle when
    // turning) and the PI axis, then combine into wheel drives and limit flags.
    // Updates the state mirror.
    function automatic t_drive_result predict_tick(input logic [31:0] left,
                                                   input logic [31:0] right);
        logic [31:0]        dist_meas, ang_meas, ramp_target, ramp_meas, ramp_err;
        logic [31:0]        raw_change, pi_drive, pi_other, pi_err;
        logic [63:0]        pi_acc;
        logic signed [63:0] change, err_s, brake, ratio_prod, pi_err_s, p_term, i_term;
        int                 speed, step, kick_neg, divisor, right_s, left_s, lim;
        logic [7:0]         count;
        logic [15:0]        ramp_cmd, pi_cmd, cmd_dist, cmd_ang;
        t_drive_result      res;

        dist_meas = right + left;
        ang_meas  = right - left;

        // the two modes swap which axis is ramped and which is PI-held
        if (!cfg_turn) begin
            ramp_target = cfg_target_dist;
            ramp_meas   = dist_meas;
            ramp_err    = dist_err;
            speed       = dist_speed;
            count       = straight_count;
            kick_neg    = KICK_DN_STRAIGHT;
            pi_drive    = dist_meas;
            pi_other    = ang_meas;
            pi_acc      = angle_integral;
        end else begin
            ramp_target = cfg_target_ang;
            ramp_meas   = ang_meas;
            ramp_err    = angle_err;
            speed       = angle_speed;
            count       = turn_count;
            kick_neg    = KICK_DN_TURN;
            pi_drive    = ang_meas;
            pi_other    = dist_meas;
            pi_acc      = dist_integral;
        end

        // ramped axis: error change kept to 16 signed bits, stored error follows it
        raw_change = ramp_target - ramp_meas - ramp_err;
        change     = $signed(raw_change[15:0]);
        ramp_err   = ramp_err + change[31:0];
        err_s      = $signed(ramp_err);
        brake      = change * change * BRAKE_GAIN;   // exact, no 32-bit wrap

        if (err_s <= brake && err_s >= -brake) begin
            step = -speed;                 // inside braking band: aim at zero
        end else if (err_s < 0) begin
            step = -TOP_SPEED - speed;
        end else begin
            step = TOP_SPEED - speed;
        end

        // one unit step per divider period only
        if (count != 0) begin
            step = 0;
        end else if (step > 1) begin
            step = 1;
        end else if (step < -1) begin
            step = -1;
        end
        speed   = speed + step;
        divisor = (cfg_accel_div == 0) ? 1 : int'(cfg_accel_div);
        count   = 8'((int'(count) + 1) % divisor);   // may sit above a shrunk divider

        // minimum-speed kick while not on target
        if (err_s != 0 && speed > kick_neg && speed < KICK_UP) begin
            speed = (err_s > 0) ? KICK_UP : kick_neg;
        end
        ramp_cmd = 16'(speed);

        // PI axis against the ratio-scaled driving axis (Q16, floor shift)
        ratio_prod = $signed(pi_drive) * $signed(cfg_ratio);
        pi_err     = ratio_prod[47:16] - pi_other;
        pi_err_s   = $signed(pi_err);
        pi_acc     = pi_acc + pi_err_s;
        p_term     = (pi_err_s * P_GAIN) >>> 2;
        i_term     = $signed(pi_acc) >>> 8;
        pi_cmd     = p_term[15:0] + i_term[15:0];

        if (!cfg_turn) begin
            dist_err       = ramp_err;
            dist_speed     = speed;
            straight_count = count;
            angle_err      = pi_err;
            angle_integral = pi_acc;
            cmd_dist       = ramp_cmd;
            cmd_ang        = pi_cmd;
        end else begin
            angle_err      = ramp_err;
            angle_speed    = speed;
            turn_count     = count;
            dist_err       = pi_err;
            dist_integral  = pi_acc;
            cmd_ang        = ramp_cmd;
            cmd_dist       = pi_cmd;
        end

        res.right_drive = cmd_dist + cmd_ang;
        res.left_drive  = cmd_dist - cmd_ang;
        right_s         = $signed(res.right_drive);
        left_s          = $signed(res.left_drive);
        lim             = int'(cfg_limit);
        res.left_over   = (left_s > lim || left_s < -lim);
        res.right_over  = (right_s > lim || right_s < -lim);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Transfer helpers
    // ------------------------------------------------------------------

    // Offer one tick; tvalid is left high so back-to-back ticks need no bubble.
    task automatic send_tick(input logic [31:0] left, input logic [31:0] right,
                             output t_drive_result want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        want = predict_tick(left, right);
        pending_drives.push_back(want);
        ticks_sent++;
    endtask

    // Drop tvalid and hold off until every predicted drive has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
    endtask

    // Config valid is left high between writes; apply_setup lowers it.
    task automatic write_reg(input ddpl_pkg::t_cfg_idx idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            ddpl_pkg::CFG_MODE:            cfg_turn        = value[0];
            ddpl_pkg::CFG_TARGET_DISTANCE: cfg_target_dist = value;
            ddpl_pkg::CFG_TARGET_ANGLE:    cfg_target_ang  = value;
            ddpl_pkg::CFG_SPEED_RATIO:     cfg_ratio       = value[15:0];
            ddpl_pkg::CFG_ACCEL_DIVIDER:   cfg_accel_div   = value[7:0];
            ddpl_pkg::CFG_DRIVE_LIMIT:     cfg_limit       = value[14:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Write all six registers; unused upper bits carry noise.
    task automatic apply_setup(input t_drive_setup s);
        logic [31:0] noise;
        noise = $urandom;
        write_reg(ddpl_pkg::CFG_MODE,            {noise[31:1], s.turn});
        write_reg(ddpl_pkg::CFG_TARGET_DISTANCE, s.target_dist);
        write_reg(ddpl_pkg::CFG_TARGET_ANGLE,    s.target_ang);
        write_reg(ddpl_pkg::CFG_SPEED_RATIO,     {noise[15:0], s.ratio});
        write_reg(ddpl_pkg::CFG_ACCEL_DIVIDER,   {noise[31:8], s.accel_div});
        write_reg(ddpl_pkg::CFG_DRIVE_LIMIT,     {noise[16:0], s.limit});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int kind);
        case (kind)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
            default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
        endcase
    endtask

    // Setpoints near the current position so braking and kicks come into play.
    function automatic t_drive_setup random_setup();
        t_drive_setup s;
        logic [31:0]  d0, a0;
        d0 = pos_right + pos_left;
        a0 = pos_right - pos_left;
        s.turn        = $urandom_range(1);
        s.target_dist = ($urandom_range(4) == 0) ? $urandom
                        : d0 + 32'($urandom_range(40000)) - 32'd20000;
        s.target_ang  = ($urandom_range(4) == 0) ? $urandom
                        : a0 + 32'($urandom_range(40000)) - 32'd20000;
        s.ratio       = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
        case ($urandom_range(5))
            0: s.accel_div = 8'd0;
            1: s.accel_div = 8'd1;
            2: s.accel_div = 8'd255;
            default: s.accel_div = 8'($urandom_range(2, 12));
        endcase
        s.limit = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(4000));
        return s;
    endfunction

    // Closed-loop trajectory: wheels mostly follow the predicted drives, with
    // random walks, jumps beyond the 16-bit error change and raw noise mixed in.
    task automatic run_trajectory(input int n_items, input int shift);
        t_drive_result res;
        int            delta_r, delta_l, pick;
        for (int n = 0; n < n_items; n++) begin
            send_tick(pos_left, pos_right, res);
            pick = $urandom_range(99);
            if (pick < 70) begin
                delta_r = int'($signed(res.right_drive)) >>> shift;
                delta_l = int'($signed(res.left_drive)) >>> shift;
                delta_r += int'($urandom_range(16)) - 8;
                delta_l += int'($urandom_range(16)) - 8;
                pos_right += delta_r;
                pos_left  += delta_l;
            end else if (pick < 85) begin
                pos_right += int'($urandom_range(600)) - 300;
                pos_left  += int'($urandom_range(600)) - 300;
            end else if (pick < 93) begin
                delta_r = int'($urandom_range(100000, 20000));
                delta_l = int'($urandom_range(100000, 20000));
                pos_right += $urandom_range(1) ? delta_r : -delta_r;
                pos_left  += $urandom_range(1) ? delta_l : -delta_l;
            end else begin
                pos_right = $urandom;
                pos_left  = $urandom;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Position extremes, wraps, both modes, kicks, braking and truncated change.
    task automatic test_directed();
        t_drive_setup  s;
        t_drive_result res;
        set_idling(0);

        // reset register values: divider 5, limit 3000, straight
        send_tick(32'd0, 32'd0, res);
        send_tick(32'd100, -32'sd50, res);
        wait_drained();

        // straight, quarter ratio, step every tick, zero limit
        s = '{1'b0, 32'd1000, 32'd0, 16'h4000, 8'd1, 15'd0};
        apply_setup(s);
        send_tick(32'd0, 32'd0, res);                 // big change: brake, then kick
        send_tick(32'd0, 32'd0, res);                 // no change: ramp away
        send_tick(32'd500, 32'd500, res);             // on target
        send_tick(32'd500, 32'd500, res);
        send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, res); // sum wraps
        send_tick(32'h8000_0000, 32'h8000_0000, res);
        send_tick(32'h8000_0000, 32'h7FFF_FFFF, res); // difference wraps
        send_tick(32'h7FFF_FFFF, 32'h8000_0000, res);
        send_tick(32'hFFFF_0000, 32'h0000_FFFF, res);
        send_tick(32'h5555_5555, 32'hAAAA_AAAA, res);
        wait_drained();

        // turn, most negative ratio, zero divider, widest limit
        s = '{1'b1, 32'h7FFF_FFFF, -32'sd2000, 16'h8000, 8'd0, 15'h7FFF};
        apply_setup(s);
        send_tick(32'd1000, -32'sd1000, res);         // on angle target
        send_tick(32'd0, 32'd0, res);
        send_tick(32'd0, 32'd0, res);
        send_tick(32'd40000, -32'sd40000, res);       // change beyond 16 bits
        send_tick(32'h8000_0000, 32'h7FFF_FFFF, res);
        send_tick(32'h7FFF_FFFF, 32'h8000_0000, res);
        wait_drained();

        // back to straight: state kept across the switch, slowest divider
        s = '{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 8'd255, 15'd3000};
        apply_setup(s);
        send_tick(32'd0, 32'd0, res);
        send_tick(32'h8000_0000, 32'd0, res);
        send_tick(32'd1, 32'hFFFF_FFFF, res);
        send_tick(32'hFFFF_FFFF, 32'd1, res);
        wait_drained();
    endtask

    // Two extreme setups, then random ones, each with a trajectory and one idling mix; drains between.
    task automatic test_random_phases();
        t_drive_setup s;
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                s = '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 8'd255, 15'h7FFF};
            end else if (phase == 1) begin
                s = '{1'b0, 32'h8000_0000, 32'h8000_0000, 16'h8000, 8'd0, 15'd0};
            end else begin
                if ($urandom_range(3) == 0) begin
                    pos_left  = $urandom;
                    pos_right = $urandom;
                end
                s = random_setup();
            end
            set_idling(phase % 4);
            apply_setup(s);
            run_trajectory(PHASE_TICKS, $urandom_range(3, 8));
            wait_drained();
        end
    endtask

    // Output held off for a long stretch while ticks keep coming: the block
    // fills and must stall its input without losing a result.
    task automatic test_backpressure();
        set_idling(0);
        apply_setup(random_setup());
        hold_requests++;
        run_trajectory(40, 5);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------

    // m_tready: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_cnt    = HOLD_LEN;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    t_drive_result seen_drive, want_drive;

    // every output transfer is matched against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            seen_drive = m_tdata[33:0];
            if (pending_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected drive result: right %0d left %0d flags %b%b",
                             $realtime, $signed(seen_drive.right_drive),
                             $signed(seen_drive.left_drive),
                             seen_drive.left_over, seen_drive.right_over);
            end else begin
                want_drive = pending_drives.pop_front();
                drives_checked++;
                if (seen_drive.right_drive !== want_drive.right_drive ||
                    seen_drive.left_drive  !== want_drive.left_drive  ||
                    seen_drive.left_over   !== want_drive.left_over   ||
                    seen_drive.right_over  !== want_drive.right_over) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] drive %0d: right exp %0d got %0d, left exp %0d got %0d",
                                 $realtime, drives_checked,
                                 $signed(want_drive.right_drive),
                                 $signed(seen_drive.right_drive),
                                 $signed(want_drive.left_drive),
                                 $signed(seen_drive.left_drive));
                        $display("    left_over exp %b got %b, right_over exp %b got %b",
                                 want_drive.left_over, seen_drive.left_over,
                                 want_drive.right_over, seen_drive.right_over);
                    end
                end
            end
        end
    end

    // ends the run if no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d drives outstanding",
                     idle_cycles, pending_drives.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phases();
        test_backpressure();

        wait_drained();
        repeat (20) @(posedge i_clk);   // catch any stray late result

        $display("Covered %0d ticks, %0d drives checked, %0d register writes, %0d mismatches.",
                 ticks_sent, drives_checked, cfg_writes, mismatches);
        $display("Both modes, register extremes, a long output hold-off, four idling mixes.");
        if (mismatches == 0 && pending_drives.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
